// ----- hw/rtl/wmp_pkg.sv -----
// ----------------------------------------------------------------------------
// wmp_pkg: shared types for the waveform min/max peak block
// Request and response payloads, register indexes and the front-to-back job.
// ----------------------------------------------------------------------------
package wmp_pkg;

   localparam int SAMPLE_W = 16;

   localparam logic [1:0] CSR_COLUMN_COUNT  = 2'd0;
   localparam logic [1:0] CSR_FRAME_TOTAL   = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd2;

   typedef struct packed {
      logic                       last_frame;
      logic signed [SAMPLE_W-1:0] sample_7;
      logic signed [SAMPLE_W-1:0] sample_6;
      logic signed [SAMPLE_W-1:0] sample_5;
      logic signed [SAMPLE_W-1:0] sample_4;
      logic signed [SAMPLE_W-1:0] sample_3;
      logic signed [SAMPLE_W-1:0] sample_2;
      logic signed [SAMPLE_W-1:0] sample_1;
      logic signed [SAMPLE_W-1:0] sample_0;
   } req_type;

   typedef struct packed {
      logic                       last_column;
      logic signed [SAMPLE_W-1:0] column_max;
      logic signed [SAMPLE_W-1:0] column_min;
      logic [5:0]                 column_index;
   } rsp_type;

   typedef struct packed {
      logic                       last_frame;
      logic [5:0]                 column;
      logic signed [SAMPLE_W-1:0] mono;
   } job_type;

endpackage

// ----- hw/rtl/wmp_front.sv -----
// ----------------------------------------------------------------------------
// wmp_front: frame classifier
// Averages channels to mono and maps the frame to its column with a
// serial divider, then pushes one job into the queue.
// ----------------------------------------------------------------------------
module wmp_front #(
   parameter int MAX_COLUMNS  = 64,
   parameter int MAX_CHANNELS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  wmp_pkg::req_type req_data,
   input  logic [6:0]      column_count,
   input  logic [31:0]     frame_total,
   input  logic [3:0]      channel_count,
   input  logic            queue_full,
   output logic            job_valid,
   output wmp_pkg::job_type job_data
);
   import wmp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_PUSH = 4'b0100,
      S_WAIT = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] fcnt_ff, fcnt_in;
   logic [38:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  bit_ff, bit_in;
   logic [3:0]  chn_ff;
   logic        last_ff;
   logic [6:0]  cols_ff;
   logic [38:0] quo_ff, quo_in;
   logic [19:0] mag_ff, mag_in;
   logic [3:0]  mrem_ff, mrem_in;
   logic [19:0] qmono_ff, qmono_in;
   logic        neg_ff;

   logic [6:0]  cols;
   logic [3:0]  chans;
   logic signed [19:0] sum;
   logic [32:0] trial;
   logic [4:0]  mtrial;
   logic [19:0] mono_mag;
   logic [6:0]  col_q;
   logic [6:0]  col_c;

   always_comb begin
      logic signed [SAMPLE_W-1:0] s [8];
      s[0] = req_data.sample_0; s[1] = req_data.sample_1;
      s[2] = req_data.sample_2; s[3] = req_data.sample_3;
      s[4] = req_data.sample_4; s[5] = req_data.sample_5;
      s[6] = req_data.sample_6; s[7] = req_data.sample_7;
      cols  = (column_count == 7'd0) ? 7'd1 :
              (column_count > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : column_count;
      chans = (channel_count == 4'd0) ? 4'd1 :
              (channel_count > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : channel_count;
      sum = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if (4'(i) < chans) sum = sum + 20'(s[i]);
      end
   end

   assign trial  = {rem_ff, num_ff[38]} - {1'b0, frame_total};
   assign mtrial = {mrem_ff, mag_ff[19]} - {1'b0, chn_ff};

   // The mono average is a shift-subtract division that runs during the
   // last twenty steps of the column division.
   always_comb begin
      state_in = state_ff;
      fcnt_in  = fcnt_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      quo_in   = quo_ff;
      mag_in   = mag_ff;
      mrem_in  = mrem_ff;
      qmono_in = qmono_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               num_in   = 39'(fcnt_ff) * 39'(cols);
               rem_in   = '0;
               quo_in   = '0;
               bit_in   = 6'd39;
               mag_in   = sum[19] ? 20'(-sum) : 20'(sum);
               mrem_in  = '0;
               qmono_in = '0;
               fcnt_in  = fcnt_ff + 32'd1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (bit_ff != 6'd0) begin
               if (!trial[32]) begin
                  rem_in = trial[31:0];
                  quo_in = {quo_ff[37:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[30:0], num_ff[38]};
                  quo_in = {quo_ff[37:0], 1'b0};
               end
               num_in = {num_ff[37:0], 1'b0};
               bit_in = bit_ff - 6'd1;
               if (bit_ff <= 6'd20) begin
                  if (!mtrial[4]) begin
                     mrem_in  = mtrial[3:0];
                     qmono_in = {qmono_ff[18:0], 1'b1};
                  end else begin
                     mrem_in  = {mrem_ff[2:0], mag_ff[19]};
                     qmono_in = {qmono_ff[18:0], 1'b0};
                  end
                  mag_in = {mag_ff[18:0], 1'b0};
               end
            end
            if (bit_ff == 6'd0) state_in = S_PUSH;
         end
         S_PUSH: begin
            if (!queue_full) state_in = last_ff ? S_WAIT : S_IDLE;
         end
         S_WAIT: begin
            if (!queue_full) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_PUSH && !queue_full && last_ff) fcnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
      end
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      quo_ff   <= quo_in;
      mag_ff   <= mag_in;
      mrem_ff  <= mrem_in;
      qmono_ff <= qmono_in;
      if (state_ff == S_IDLE && start) begin
         chn_ff  <= chans;
         last_ff <= req_data.last_frame;
         cols_ff <= cols;
         neg_ff  <= sum[19];
      end
   end

   assign col_q = (frame_total == 32'd0) ? 7'd0 :
                  (quo_ff[38:7] != 32'd0) ? 7'h7f : quo_ff[6:0];
   assign col_c = (col_q > cols_ff - 7'd1) ? cols_ff - 7'd1 : col_q;
   assign mono_mag = qmono_ff;

   assign busy      = (state_ff != S_IDLE);
   assign job_valid = (state_ff == S_PUSH) && !queue_full;
   assign job_data.last_frame = last_ff;
   assign job_data.column     = col_c[5:0];
   assign job_data.mono       = neg_ff ? SAMPLE_W'(-mono_mag) : SAMPLE_W'(mono_mag);

   a_push_only_in_push: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> state_ff == S_PUSH) else $error("job pushed outside push state");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> 7'(job_data.column) < cols_ff) else $error("column out of range");

endmodule

// ----- hw/rtl/wmp_queue.sv -----
// ----------------------------------------------------------------------------
// wmp_queue: job queue
// A short first-in first-out buffer between the classifier and the store.
// ----------------------------------------------------------------------------
module wmp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wmp_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output wmp_pkg::job_type pop_data
);
   import wmp_pkg::*;

   job_type    slot_ff [2];
   logic [0:0] wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wr_ff] <= push_data;
   end

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");

endmodule

// ----- hw/rtl/wmp_back.sv -----
// ----------------------------------------------------------------------------
// wmp_back: column store and readout
// Updates the per-column extremes, and on the last frame finds the peak,
// normalizes each column with a serial divider and clears the store.
// ----------------------------------------------------------------------------
module wmp_back #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_ready,
   input  wmp_pkg::job_type job_data,
   output logic             job_pop,
   input  logic [6:0]       column_count,
   output logic             rsp_valid,
   output wmp_pkg::rsp_type rsp_data
);
   import wmp_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS) > 0 ? $clog2(MAX_COLUMNS) : 1;

   typedef enum logic [7:0] {
      S_TAKE = 8'b00000001,
      S_UPD  = 8'b00000010,
      S_PRD  = 8'b00000100,
      S_PEAK = 8'b00001000,
      S_ORD  = 8'b00010000,
      S_OLAT = 8'b00100000,
      S_ODIV = 8'b01000000,
      S_EMIT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic signed [SAMPLE_W-1:0] min_mem [MAX_COLUMNS];
   logic signed [SAMPLE_W-1:0] max_mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] valid_ff;
   logic signed [SAMPLE_W-1:0] rmin_ff, rmax_ff;
   logic        rvalid_ff;
   job_type     job_ff;
   logic [CW-1:0] rd_addr, idx_ff;
   logic [6:0]  cols_ff;
   logic [16:0] peak_ff;
   logic [31:0] num_ff [2];
   logic [16:0] rem_ff [2];
   logic [31:0] quo_ff [2];
   logic [5:0]  step_ff;
   logic        negs_ff [2];
   logic [16:0] mags_ff [2];
   logic signed [SAMPLE_W-1:0] cmin, cmax, newmin, newmax, omin, omax;
   logic [6:0]  cols;
   logic        clear_all;
   logic        wr_en;
   logic signed [SAMPLE_W-1:0] out_v [2];

   assign cols = (column_count == 7'd0) ? 7'd1 :
                 (column_count > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : column_count;
   assign cmin = rvalid_ff ? rmin_ff : '0;
   assign cmax = rvalid_ff ? rmax_ff : '0;
   assign newmin = (job_ff.mono < cmin) ? job_ff.mono : cmin;
   assign newmax = (job_ff.mono > cmax) ? job_ff.mono : cmax;
   assign rd_addr = (state_ff == S_TAKE) ? job_data.column[CW-1:0] : idx_ff;
   assign wr_en = (state_ff == S_UPD);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         min_mem[job_ff.column[CW-1:0]] <= newmin;
         max_mem[job_ff.column[CW-1:0]] <= newmax;
      end
      rmin_ff   <= min_mem[rd_addr];
      rmax_ff   <= max_mem[rd_addr];
      rvalid_ff <= valid_ff[rd_addr] &&
                   !(wr_en && job_ff.column[CW-1:0] == rd_addr);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_TAKE: if (job_ready) state_in = S_UPD;
         S_UPD:  state_in = job_ff.last_frame ? S_PRD : S_TAKE;
         S_PRD:  state_in = S_PEAK;
         S_PEAK: state_in = (7'(idx_ff) == cols_ff - 7'd1) ? S_ORD : S_PRD;
         S_ORD:  state_in = S_OLAT;
         S_OLAT: state_in = S_ODIV;
         S_ODIV: if (peak_ff == 17'd0 || step_ff == 6'd0) state_in = S_EMIT;
         S_EMIT: state_in = (7'(idx_ff) == cols_ff - 7'd1) ? S_TAKE : S_ORD;
         default: state_in = S_TAKE;
      endcase
   end

   assign clear_all = (state_ff == S_EMIT) && (7'(idx_ff) == cols_ff - 7'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_TAKE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clear_all) valid_ff <= '0;
         else if (wr_en) valid_ff[job_ff.column[CW-1:0]] <= 1'b1;
      end
      if (state_ff == S_TAKE) job_ff <= job_data;
      if (state_ff == S_UPD) begin
         idx_ff  <= '0;
         peak_ff <= '0;
         cols_ff <= cols;
      end
      if (state_ff == S_PEAK) begin
         logic [16:0] a, b, m;
         a = cmin[15] ? 17'(-17'(cmin)) : 17'(cmin);
         b = cmax[15] ? 17'(-17'(cmax)) : 17'(cmax);
         m = (a > b) ? a : b;
         if (m > peak_ff) peak_ff <= m;
         idx_ff <= (7'(idx_ff) == cols_ff - 7'd1) ? '0 : idx_ff + 1'b1;
      end
      if (state_ff == S_OLAT) begin
         negs_ff[0] <= cmin[15];
         negs_ff[1] <= cmax[15];
         mags_ff[0] <= cmin[15] ? 17'(-17'(cmin)) : 17'(cmin);
         mags_ff[1] <= cmax[15] ? 17'(-17'(cmax)) : 17'(cmax);
         num_ff[0]  <= {(cmin[15] ? 17'(-17'(cmin)) : 17'(cmin)), 15'd0};
         num_ff[1]  <= {(cmax[15] ? 17'(-17'(cmax)) : 17'(cmax)), 15'd0};
         rem_ff[0]  <= '0;
         rem_ff[1]  <= '0;
         quo_ff[0]  <= '0;
         quo_ff[1]  <= '0;
         step_ff    <= 6'd32;
      end
      if (state_ff == S_ODIV && step_ff != 6'd0) begin
         for (int k = 0; k < 2; k++) begin
            logic [17:0] t;
            t = {rem_ff[k], num_ff[k][31]} - {1'b0, peak_ff};
            if (!t[17]) begin
               rem_ff[k] <= t[16:0];
               quo_ff[k] <= {quo_ff[k][30:0], 1'b1};
            end else begin
               rem_ff[k] <= {rem_ff[k][15:0], num_ff[k][31]};
               quo_ff[k] <= {quo_ff[k][30:0], 1'b0};
            end
            num_ff[k] <= {num_ff[k][30:0], 1'b0};
         end
         step_ff <= step_ff - 6'd1;
      end
      if (state_ff == S_EMIT) idx_ff <= idx_ff + 1'b1;
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         if (peak_ff == 17'd0) out_v[k] = SAMPLE_W'(negs_ff[k] ? -mags_ff[k] : mags_ff[k]);
         else if (negs_ff[k])
            out_v[k] = (quo_ff[k] > 32'd32768) ? 16'sh8000 : SAMPLE_W'(-quo_ff[k]);
         else out_v[k] = (quo_ff[k] > 32'd32767) ? 16'sh7fff : SAMPLE_W'(quo_ff[k]);
      end
      omin = out_v[0];
      omax = out_v[1];
   end

   assign job_pop   = (state_ff == S_TAKE) && job_ready;
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_data.column_index = 6'(idx_ff);
   assign rsp_data.column_min   = omin;
   assign rsp_data.column_max   = omax;
   assign rsp_data.last_column  = (7'(idx_ff) == cols_ff - 7'd1);

   a_emit_then: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_column |=> !rsp_valid) else $error("emit burst");
   a_clear_last: assert property (@(posedge clock) disable iff (reset)
      clear_all |=> valid_ff == '0) else $error("store not cleared");
   a_pop_take: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff == S_UPD) else $error("pop lost");

endmodule

// ----- hw/rtl/waveform_minmax_peaks.sv -----
// ----------------------------------------------------------------------------
// waveform_minmax_peaks: waveform min/max decimation into display columns
// Builds per-column extremes from audio frames and reads them out normalized.
// ----------------------------------------------------------------------------
// A frame is taken when start is high and busy is low. The front part runs
// each frame through its 39-step serial column divider, stalling while the
// queue is full, and hands the job through a two-entry queue to the store,
// which reads and then writes the column for each update. On a last frame the
// store scans all active columns for the peak, then emits one result per
// column after its 32-step normalizing divider; results cannot be held
// off and busy stays high until the readout is done.
module waveform_minmax_peaks #(
   parameter int MAX_COLUMNS  = 64,
   parameter int MAX_CHANNELS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  wmp_pkg::req_type req_data,
   output logic             rsp_strobe,
   output wmp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import wmp_pkg::*;

   logic [6:0]  column_count_ff;
   logic [31:0] frame_total_ff;
   logic [3:0]  channel_count_ff;
   logic        front_busy, q_full, q_push, q_ne, q_pop;
   logic        last_pending_ff;
   job_type     push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff  <= 7'd64;
         frame_total_ff   <= '0;
         channel_count_ff <= 4'd1;
         last_pending_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_COLUMN_COUNT:  column_count_ff  <= csr_data[6:0];
               CSR_FRAME_TOTAL:   frame_total_ff   <= csr_data;
               CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[3:0];
               default: ;
            endcase
         end
         if (q_push && push_data.last_frame) last_pending_ff <= 1'b1;
         else if (rsp_strobe && rsp_data.last_column) last_pending_ff <= 1'b0;
      end
   end

   wmp_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
      .clock(clock), .reset(reset), .start(start && !busy), .busy(front_busy),
      .req_data(req_data), .column_count(column_count_ff),
      .frame_total(frame_total_ff), .channel_count(channel_count_ff),
      .queue_full(q_full), .job_valid(q_push), .job_data(push_data));

   wmp_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(push_data),
      .full(q_full), .pop(q_pop), .not_empty(q_ne), .pop_data(pop_data));

   wmp_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
      .clock(clock), .reset(reset), .job_ready(q_ne), .job_data(pop_data),
      .job_pop(q_pop), .column_count(column_count_ff),
      .rsp_valid(rsp_strobe), .rsp_data(rsp_data));

   assign busy = front_busy || last_pending_ff;

endmodule
